FILE: src/chtc_pkg.sv
// ----------------------------------------------------------------------------
// chtc_pkg: shared types and constants for the checked sensor word converter
// Holds the CRC-8 constants, the conversion spans and offsets, the byte-wise
// CRC step and the structs passed between the lanes and the merge stage.
// ----------------------------------------------------------------------------
package chtc_pkg;

    // CRC-8 as used by the sensor: poly x^8+x^5+x^4+1, preset all ones
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int CHECK_W = 8;
    localparam int SPAN_W  = 15;
    localparam int PROD_W  = RAW_W + SPAN_W;
    localparam int VALUE_W = 16;
    localparam int HUM_W   = 15;

    // Divisor of the full-scale conversion (2^16 - 1)
    localparam logic [RAW_W:0] FULL_SCALE = 17'd65535;

    // Spans and offsets in hundredths of a unit
    localparam logic [SPAN_W-1:0]         SPAN_CELSIUS    = 15'd17500;
    localparam logic [SPAN_W-1:0]         SPAN_FAHRENHEIT = 15'd31500;
    localparam logic [SPAN_W-1:0]         SPAN_HUMIDITY   = 15'd12500;
    localparam logic signed [VALUE_W-1:0] OFS_CELSIUS     = -16'sd4500;
    localparam logic signed [VALUE_W-1:0] OFS_FAHRENHEIT  = -16'sd4900;
    localparam logic signed [VALUE_W-1:0] OFS_HUMIDITY    = -16'sd600;

    // Temperature unit register codes
    localparam logic UNIT_CELSIUS    = 1'b0;
    localparam logic UNIT_FAHRENHEIT = 1'b1;

    // Pipeline load strobes shared by lanes and merge stage
    typedef struct packed {
        logic load_s1;
        logic load_s2;
    } pipe_ctrl_t;

    // What one lane reports to the merge stage
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      ok;
    } lane_result_t;

    // Shift one byte (already XORed into the CRC) through eight CRC steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] d);
        logic [7:0] c;
        c = d;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/chtc_lane.sv
// ----------------------------------------------------------------------------
// chtc_lane: one check-and-convert lane
// Stage 1 runs the CRC over the high byte and forms span * raw. The lane
// output finishes the CRC over the low byte, divides by 65535 and adds the
// offset; a value whose check fails is forced to zero.
// ----------------------------------------------------------------------------
module chtc_lane (
    input  logic                                    aclk,
    input  chtc_pkg::pipe_ctrl_t                    ctrl,
    input  logic [chtc_pkg::RAW_W-1:0]              raw,
    input  logic [chtc_pkg::CHECK_W-1:0]            check,
    input  logic [chtc_pkg::SPAN_W-1:0]             span,
    input  logic signed [chtc_pkg::VALUE_W-1:0]     offset,
    output chtc_pkg::lane_result_t                  result
);

    logic [chtc_pkg::PROD_W-1:0]          prod_reg,   prod_next;
    logic [7:0]                           crc_hi_reg, crc_hi_next;
    logic [7:0]                           raw_lo_reg;
    logic [chtc_pkg::CHECK_W-1:0]         check_reg;
    logic signed [chtc_pkg::VALUE_W-1:0]  offset_reg;

    logic [7:0]                           crc_full;
    logic                                 crc_ok;
    logic [chtc_pkg::SPAN_W-1:0]          quo_est;
    logic [chtc_pkg::RAW_W:0]             rem_est;
    logic [chtc_pkg::SPAN_W-1:0]          quo;
    logic signed [chtc_pkg::VALUE_W:0]    sum;

    // Stage 1: high-byte CRC and the scale product
    assign crc_hi_next = chtc_pkg::crc8_byte(chtc_pkg::CRC_INIT ^ raw[15:8]);
    assign prod_next   = chtc_pkg::PROD_W'(raw) * chtc_pkg::PROD_W'(span);

    always_ff @(posedge aclk) begin
        if (ctrl.load_s1) begin
            prod_reg   <= prod_next;
            crc_hi_reg <= crc_hi_next;
            raw_lo_reg <= raw[7:0];
            check_reg  <= check;
            offset_reg <= offset;
        end
    end

    // Finish the CRC over the low byte and compare with the received byte
    assign crc_full = chtc_pkg::crc8_byte(crc_hi_reg ^ raw_lo_reg);
    assign crc_ok   = (crc_full == check_reg);

    // Divide by 2^16-1: estimate with a shift, then correct by one.
    // The remainder estimate stays below twice the divisor.
    assign quo_est = prod_reg[chtc_pkg::PROD_W-1:16];
    assign rem_est = {1'b0, prod_reg[15:0]} + {2'b00, quo_est};
    assign quo     = (rem_est >= chtc_pkg::FULL_SCALE) ? quo_est + 15'd1 : quo_est;

    // Add offset, drop value on a failed check
    assign sum = {offset_reg[chtc_pkg::VALUE_W-1], offset_reg} + $signed({2'b00, quo});

    assign result.ok    = crc_ok;
    assign result.value = crc_ok ? sum[chtc_pkg::VALUE_W-1:0] : '0;

endmodule

FILE: src/chtc_merge.sv
// ----------------------------------------------------------------------------
// chtc_merge: merge stage
// Registers both lane results into the output word and forms the combined
// check flag.
// ----------------------------------------------------------------------------
module chtc_merge (
    input  logic                      aclk,
    input  chtc_pkg::pipe_ctrl_t      ctrl,
    input  chtc_pkg::lane_result_t    temp_res,
    input  chtc_pkg::lane_result_t    hum_res,
    output logic [31:0]               tdata,
    output logic [2:0]                tuser
);

    logic [chtc_pkg::VALUE_W-1:0] temp_reg;
    logic [chtc_pkg::HUM_W-1:0]   hum_reg;
    logic [2:0]                   flags_reg, flags_next;

    // Combine lane flags: temp_ok, hum_ok, both_ok from the low bit up
    assign flags_next = {temp_res.ok & hum_res.ok, hum_res.ok, temp_res.ok};

    // Load the output word when stage 2 advances
    always_ff @(posedge aclk) begin
        if (ctrl.load_s2) begin
            temp_reg  <= temp_res.value;
            hum_reg   <= hum_res.value[chtc_pkg::HUM_W-1:0];
            flags_reg <= flags_next;
        end
    end

    assign tdata = {1'b0, hum_reg, temp_reg};
    assign tuser = flags_reg;

endmodule

FILE: src/crc_checked_humidity_temp_convert.sv
// ----------------------------------------------------------------------------
// crc_checked_humidity_temp_convert: CRC-checked sensor word conversion
// Checks the raw temperature and humidity words against their CRC-8 bytes
// and converts them to hundredths of a unit, in two parallel lanes.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[47:0]
//   m_       out  m_tvalid/m_tready  m_tdata[31:0], m_tuser[2:0]
//   cfg_     in   cfg_valid/cfg_ready cfg_data[0]  (temperature unit)
//
// One request per cycle while the output is not stalled; an accepted request
// passes the lane register (CRC high byte plus multiply) and then the output
// register, which takes the CRC low byte plus divide correction.
// Reset clears the stage valid flags and selects Celsius.
// A stalled output holds its word; input is refused only when both
// stages are full and m_tready is low.
// ----------------------------------------------------------------------------
module crc_checked_humidity_temp_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // temp_raw, temp_check, hum_raw, hum_check
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // temperature[15:0], humidity[30:16], zero pad
    output logic [2:0]  m_tuser,   // temp_ok, hum_ok, both_ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // temperature_unit
);

    logic                 unit_reg, unit_next;
    logic                 v1_reg,   v1_next;
    logic                 v2_reg,   v2_next;
    logic                 adv1, adv2, out_free;
    chtc_pkg::pipe_ctrl_t ctrl;

    logic [chtc_pkg::SPAN_W-1:0]         temp_span;
    logic signed [chtc_pkg::VALUE_W-1:0] temp_offset;
    chtc_pkg::lane_result_t              temp_res, hum_res;

    // Configuration: always ready, latch unit select
    assign cfg_ready = 1'b1;
    assign unit_next = (cfg_valid && cfg_ready) ? cfg_data[0] : unit_reg;

    // Pipeline advance: each stage moves when the one after it frees up
    assign out_free = !v2_reg || m_tready;
    assign adv2     = v1_reg && out_free;
    assign s_tready = !v1_reg || out_free;
    assign adv1     = s_tvalid && s_tready;

    assign v1_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
    assign v2_next = adv2 ? 1'b1 : (m_tready ? 1'b0 : v2_reg);

    assign ctrl.load_s1 = adv1;
    assign ctrl.load_s2 = adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= chtc_pkg::UNIT_CELSIUS;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            unit_reg <= unit_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
        end
    end

    // Select temperature scale by unit
    assign temp_span   = (unit_reg == chtc_pkg::UNIT_FAHRENHEIT) ?
                         chtc_pkg::SPAN_FAHRENHEIT : chtc_pkg::SPAN_CELSIUS;
    assign temp_offset = (unit_reg == chtc_pkg::UNIT_FAHRENHEIT) ?
                         chtc_pkg::OFS_FAHRENHEIT : chtc_pkg::OFS_CELSIUS;

    // Temperature lane
    chtc_lane u_temp_lane (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .raw    (s_tdata[15:0]),
        .check  (s_tdata[23:16]),
        .span   (temp_span),
        .offset (temp_offset),
        .result (temp_res)
    );

    // Humidity lane
    chtc_lane u_hum_lane (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .raw    (s_tdata[39:24]),
        .check  (s_tdata[47:40]),
        .span   (chtc_pkg::SPAN_HUMIDITY),
        .offset (chtc_pkg::OFS_HUMIDITY),
        .result (hum_res)
    );

    // Merge lanes into the output register
    chtc_merge u_merge (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .temp_res (temp_res),
        .hum_res  (hum_res),
        .tdata    (m_tdata),
        .tuser    (m_tuser)
    );

    assign m_tvalid = v2_reg;

    // Combined flag agrees with the lane flags
    a_both_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2] == (m_tuser[0] & m_tuser[1])))
        else $error("both_ok differs from temp_ok & hum_ok");

    // Failed temperature check gives zero temperature
    a_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[15:0] == 16'd0))
        else $error("temperature not zero on failed check");

    // Failed humidity check gives zero humidity
    a_hum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[30:16] == 15'd0))
        else $error("humidity not zero on failed check");

    // Input is refused only when the whole pipe is full and stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && v1_reg))
        else $error("input refused while pipeline has room");

endmodule

FILE: dv/reading_tb_pkg.sv
// ----------------------------------------------------------------------------
// reading_tb_pkg: shared helpers for the sensor reading testbench
// Holds the bit-serial CRC-8 of one 16-bit sensor word. The checker uses it
// to predict the check flags, and the stimulus uses it to build requests
// that carry a correct check byte.
// ----------------------------------------------------------------------------
package reading_tb_pkg;

    // CRC-8 over one word, most significant bit first
    function automatic logic [7:0] word_crc8(input logic [15:0] word);
        logic [7:0] crc;
        logic       feedback;
        crc = chtc_pkg::CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            feedback = crc[7] ^ word[i];
            crc      = {crc[6:0], 1'b0};
            if (feedback) begin
                crc = crc ^ chtc_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

FILE: dv/sensor_reading_checker.sv
// ----------------------------------------------------------------------------
// sensor_reading_checker: scoreboard for the checked sensor word converter
// Watches the request, result and unit channels. Every accepted request is
// converted here into the expected reading, using the unit in force at that
// time, and every accepted result is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module sensor_reading_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    output int unsigned error_count,
    output int unsigned readings_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [14:0] humidity;
        logic               temp_ok;
        logic               hum_ok;
        logic               both_ok;
    } reading_t;

    reading_t    expected_readings[$];
    logic        temp_unit = chtc_pkg::UNIT_CELSIUS;
    int unsigned errors    = 0;

    // offset + floor(span * raw / full scale)
    function automatic int scale_raw(input logic [15:0] raw, input logic [14:0] span,
                                     input logic signed [15:0] offset);
        longint quotient;
        quotient = (longint'(span) * longint'(raw)) / longint'(chtc_pkg::FULL_SCALE);
        return int'(offset) + int'(quotient);
    endfunction

    // Check both words and convert the ones that pass
    function automatic reading_t convert_reading(input logic [47:0] req, input logic unit);
        reading_t    r;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        int          t_val;
        int          h_val;
        t_raw     = req[15:0];
        h_raw     = req[39:24];
        r.temp_ok = (reading_tb_pkg::word_crc8(t_raw) == req[23:16]);
        r.hum_ok  = (reading_tb_pkg::word_crc8(h_raw) == req[47:40]);
        r.both_ok = r.temp_ok && r.hum_ok;
        t_val     = 0;
        h_val     = 0;
        if (r.temp_ok) begin
            if (unit == chtc_pkg::UNIT_FAHRENHEIT) begin
                t_val = scale_raw(t_raw, chtc_pkg::SPAN_FAHRENHEIT,
                                  chtc_pkg::OFS_FAHRENHEIT);
            end else begin
                t_val = scale_raw(t_raw, chtc_pkg::SPAN_CELSIUS, chtc_pkg::OFS_CELSIUS);
            end
        end
        if (r.hum_ok) begin
            h_val = scale_raw(h_raw, chtc_pkg::SPAN_HUMIDITY, chtc_pkg::OFS_HUMIDITY);
        end
        r.temperature = t_val[15:0];
        r.humidity    = h_val[14:0];
        return r;
    endfunction

    // Count a failure, report only the first few
    task automatic note_error(input string what);
        errors++;
        if (errors <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Track the unit, queue predictions, compare results
    always @(posedge aclk) begin : monitor
        reading_t seen;
        reading_t want;
        if (!aresetn) begin
            temp_unit <= chtc_pkg::UNIT_CELSIUS;
        end else begin
            if (cfg_valid && cfg_ready) begin
                temp_unit <= cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(convert_reading(s_tdata, temp_unit));
            end
            if (m_tvalid && m_tready) begin
                seen.temperature = m_tdata[15:0];
                seen.humidity    = m_tdata[30:16];
                seen.temp_ok     = m_tuser[0];
                seen.hum_ok      = m_tuser[1];
                seen.both_ok     = m_tuser[2];
                if (expected_readings.size() == 0) begin
                    note_error($sformatf("unexpected reading: temp %0d hum %0d ok %b%b%b",
                        seen.temperature, seen.humidity,
                        seen.temp_ok, seen.hum_ok, seen.both_ok));
                end else begin
                    want = expected_readings.pop_front();
                    if (seen.temperature != want.temperature || seen.humidity != want.humidity
                        || seen.temp_ok != want.temp_ok || seen.hum_ok != want.hum_ok
                        || seen.both_ok != want.both_ok) begin
                        note_error({
                            $sformatf("reading mismatch: expected temp %0d hum %0d ok %b%b%b",
                                want.temperature, want.humidity,
                                want.temp_ok, want.hum_ok, want.both_ok),
                            $sformatf(", got temp %0d hum %0d ok %b%b%b",
                                seen.temperature, seen.humidity,
                                seen.temp_ok, seen.hum_ok, seen.both_ok)});
                    end
                end
            end
            readings_pending <= expected_readings.size();
            error_count      <= errors;
        end
    end

endmodule

FILE: dv/tb_crc_checked_humidity_temp_convert.sv
// ----------------------------------------------------------------------------
// tb_crc_checked_humidity_temp_convert: testbench for the sensor converter
// Drives measurement requests in three phases (Celsius, Fahrenheit, Celsius)
// with directed corner words and mostly well-formed random words, varies the
// idling on both channels and holds the result side off once for a long
// stretch. A separate checker predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_crc_checked_humidity_temp_convert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 250;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;      // temperature[15:0], humidity[30:16], zero pad
    logic [2:0]  m_tuser;      // temp_ok, hum_ok, both_ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data  = '0;

    int unsigned error_count;
    int unsigned readings_pending;
    int          send_idle_pct = 11;
    int          recv_idle_pct = 49;
    logic        hold_request  = 1'b0;
    logic        hold_served   = 1'b0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    crc_checked_humidity_temp_convert i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sensor_reading_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .readings_pending (readings_pending)
    );

    // Receiver: one long hold-off on request, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [47:0] pack_request(input logic [15:0] t_raw,
                                                 input logic [7:0] t_chk,
                                                 input logic [15:0] h_raw,
                                                 input logic [7:0] h_chk);
        return {h_chk, h_raw, t_chk, t_raw};
    endfunction

    function automatic logic [47:0] clean_request(input logic [15:0] t_raw,
                                                  input logic [15:0] h_raw);
        return pack_request(t_raw, reading_tb_pkg::word_crc8(t_raw),
                            h_raw, reading_tb_pkg::word_crc8(h_raw));
    endfunction

    // Mostly uniform words, with the scale ends now and then
    function automatic logic [15:0] random_raw();
        logic [15:0] ends[6];
        ends = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
        if ($urandom_range(9) == 0) begin
            return ends[$urandom_range(5)];
        end
        return 16'($urandom);
    endfunction

    // Mostly correct check bytes, some random ones
    function automatic logic [47:0] random_request();
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic [7:0]  t_chk;
        logic [7:0]  h_chk;
        t_raw = random_raw();
        h_raw = random_raw();
        t_chk = ($urandom_range(4) == 0) ? 8'($urandom) : reading_tb_pkg::word_crc8(t_raw);
        h_chk = ($urandom_range(4) == 0) ? 8'($urandom) : reading_tb_pkg::word_crc8(h_raw);
        return pack_request(t_raw, t_chk, h_raw, h_chk);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic [47:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Drop the request line and wait until every reading is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_unit(input logic unit);
        cfg_data  <= unit;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Scale ends, each check failing alone and together
    task automatic run_directed();
        send_request(clean_request(16'h0000, 16'h0000));
        send_request(clean_request(16'hFFFF, 16'hFFFF));
        send_request(clean_request(16'h8000, 16'h7FFF));
        send_request(clean_request(16'h0001, 16'hFFFE));
        send_request(pack_request(16'h1234, ~reading_tb_pkg::word_crc8(16'h1234),
                                  16'h4321, reading_tb_pkg::word_crc8(16'h4321)));
        send_request(pack_request(16'hBEEF, reading_tb_pkg::word_crc8(16'hBEEF),
                                  16'hFFFF, reading_tb_pkg::word_crc8(16'hFFFF) ^ 8'h01));
        send_request(pack_request(16'h6666, 8'h00, 16'h9999, 8'hFF));
        send_request(clean_request(16'h5555, 16'hAAAA));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Celsius, slow receiver, one long hold-off
        write_unit(chtc_pkg::UNIT_CELSIUS);
        run_directed();
        hold_request <= 1'b1;
        run_random(RANDOM_ITEMS);

        // Fahrenheit, slow sender
        wait_idle();
        write_unit(chtc_pkg::UNIT_FAHRENHEIT);
        send_idle_pct = 49;
        recv_idle_pct <= 11;
        run_directed();
        run_random(RANDOM_ITEMS);

        // Celsius again at full rate
        wait_idle();
        write_unit(chtc_pkg::UNIT_CELSIUS);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random(RANDOM_ITEMS);
        wait_idle();

        if (error_count == 0 && readings_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
